### rtl/core/min_heap_priority_queue_unit_macros.svh
// Assertion macros used by the heap checker.
`ifndef MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MHPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("heap checker: same-cycle property violated");

// Next-cycle implication, disabled in reset.
`define MHPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("heap checker: next-cycle property violated");

`endif

### rtl/core/mhpq_pkg.sv
package mhpq_pkg;

  localparam int ZONE_W        = 8;
  localparam int KEY_W         = 31;
  localparam int OP_W          = 2;
  localparam int STATUS_W      = 2;
  localparam int FILL_W        = 7;
  localparam int DEPTH_DEFAULT = 64;

  localparam logic [OP_W-1:0] OP_PUSH     = 2'd0;
  localparam logic [OP_W-1:0] OP_POP      = 2'd1;
  localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic [KEY_W-1:0]  key;
    logic [ZONE_W-1:0] prev;
  } entry_t;

  typedef enum logic [1:0] {
    RS_PARENT,
    RS_POP,
    RS_CHILD,
    RS_SCAN
  } rsel_t;

  typedef enum logic [1:0] {
    WS_MOVING,
    WS_PARENT,
    WS_CHILD
  } wsel_t;

  typedef struct packed {
    logic                load_req;
    logic                push_start;
    logic                pop_take;
    logic                srch_init;
    logic                srch_step;
    logic                srch_hit;
    rsel_t               rsel;
    logic                wr_en;
    wsel_t               wsel;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_one;
    logic pos_zero;
    logic up_stop;
    logic dn_stop;
    logic found;
    logic scan_done;
  } flags_t;

endpackage

### rtl/core/mhpq_datapath.sv
module mhpq_datapath
  import mhpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output flags_t              flags,
  input  logic [ZONE_W-1:0]   zone_id,
  input  logic [KEY_W-1:0]    key_distance,
  input  logic [ZONE_W-1:0]   prev_zone,
  output logic [STATUS_W-1:0] status,
  output logic [ZONE_W-1:0]   out_zone,
  output logic [KEY_W-1:0]    out_distance,
  output logic [ZONE_W-1:0]   out_prev,
  output logic [FILL_W-1:0]   fill_count
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CIW = AW + 2;

  entry_t mem [DEPTH];
  entry_t rdata_a;
  entry_t rdata_b;

  logic [CW-1:0]       count;
  logic [AW-1:0]       pos;
  entry_t              moving;
  entry_t              pop_ent;
  entry_t              req;
  logic [STATUS_W-1:0] status_q;
  logic [CW-1:0]       scan;
  logic                chk_valid;
  logic [AW-1:0]       chk_idx;

  logic [AW-1:0]  raddr_a;
  logic [AW-1:0]  raddr_b;
  logic [AW-1:0]  parent_idx;
  logic [CIW-1:0] left_idx;
  logic [CIW-1:0] right_idx;
  logic [CIW-1:0] count_ext;
  logic           left_ok;
  logic           right_ok;
  logic           go_left;
  logic           go_right;
  logic [KEY_W-1:0] best_key;
  logic [AW-1:0]  child_idx;
  entry_t         wr_data;

  assign parent_idx = AW'((pos - 1'b1) >> 1);
  assign left_idx   = CIW'({pos, 1'b1});
  assign right_idx  = CIW'({pos, 1'b0}) + CIW'(2);
  assign count_ext  = CIW'(count);
  assign left_ok    = left_idx < count_ext;
  assign right_ok   = right_idx < count_ext;
  assign go_left    = left_ok && (rdata_a.key < moving.key);
  assign best_key   = go_left ? rdata_a.key : moving.key;
  assign go_right   = right_ok && (rdata_b.key < best_key);
  assign child_idx  = go_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  always_comb begin
    raddr_a = parent_idx;
    raddr_b = right_idx[AW-1:0];
    case (cmd.rsel)
      RS_PARENT: raddr_a = parent_idx;
      RS_POP: begin
        raddr_a = '0;
        raddr_b = AW'(count - 1'b1);
      end
      RS_CHILD: raddr_a = left_idx[AW-1:0];
      RS_SCAN:  raddr_a = scan[AW-1:0];
      default:  raddr_a = parent_idx;
    endcase
  end

  always_comb begin
    case (cmd.wsel)
      WS_MOVING: wr_data = moving;
      WS_PARENT: wr_data = rdata_a;
      WS_CHILD:  wr_data = go_right ? rdata_b : rdata_a;
      default:   wr_data = moving;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[pos] <= wr_data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

  always_comb begin
    flags.full      = count >= CW'(DEPTH);
    flags.empty     = count == '0;
    flags.cnt_one   = count == CW'(1);
    flags.pos_zero  = pos == '0;
    flags.up_stop   = moving.key > rdata_a.key;
    flags.dn_stop   = !go_left && !go_right;
    flags.found     = chk_valid && (rdata_a.zone == req.zone);
    flags.scan_done = !chk_valid && (scan == count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      chk_valid <= 1'b0;
    end else begin
      if (cmd.push_start) begin
        count <= count + 1'b1;
      end else if (cmd.pop_take) begin
        count <= count - 1'b1;
      end
      if (cmd.srch_init) begin
        chk_valid <= 1'b0;
      end else if (cmd.srch_step) begin
        chk_valid <= scan < count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req     <= '{zone: zone_id, key: key_distance, prev: prev_zone};
      pop_ent <= '0;
    end
    if (cmd.set_status) begin
      status_q <= cmd.status_code;
    end
    if (cmd.push_start) begin
      moving <= '{zone: zone_id, key: key_distance, prev: prev_zone};
      pos    <= AW'(count);
    end
    if (cmd.pop_take) begin
      pop_ent <= rdata_a;
      moving  <= rdata_b;
      pos     <= '0;
    end
    if (cmd.srch_init) begin
      scan <= '0;
    end else if (cmd.srch_step && (scan < count)) begin
      scan    <= scan + 1'b1;
      chk_idx <= scan[AW-1:0];
    end
    if (cmd.srch_hit) begin
      moving <= req;
      pos    <= chk_idx;
    end
    if (cmd.wr_en && (cmd.wsel == WS_PARENT)) begin
      pos <= parent_idx;
    end else if (cmd.wr_en && (cmd.wsel == WS_CHILD)) begin
      pos <= child_idx;
    end
    if (cmd.out_load) begin
      status       <= status_q;
      out_zone     <= pop_ent.zone;
      out_distance <= pop_ent.key;
      out_prev     <= pop_ent.prev;
      fill_count   <= FILL_W'(count);
    end
  end

endmodule

### rtl/core/mhpq_ctrl.sv
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] operation,
  output logic            out_valid,
  input  logic            out_ready,
  input  flags_t          flags,
  output cmd_t            cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_EV,
    S_DN_RD,
    S_DN_EV,
    S_UP_RD,
    S_UP_EV,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req    = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          case (operation)
            OP_PUSH: begin
              if (flags.full) begin
                cmd.status_code = ST_FULL;
                state_next      = S_FINISH;
              end else begin
                cmd.push_start = 1'b1;
                state_next     = S_UP_RD;
              end
            end
            OP_POP: begin
              if (flags.empty) begin
                cmd.status_code = ST_EMPTY;
                state_next      = S_FINISH;
              end else begin
                state_next = S_POP_RD;
              end
            end
            OP_DECREASE: begin
              cmd.status_code = ST_MISSING;
              cmd.srch_init   = 1'b1;
              state_next      = S_SEARCH;
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_POP_RD: begin
        cmd.rsel   = RS_POP;
        state_next = S_POP_EV;
      end
      S_POP_EV: begin
        cmd.pop_take = 1'b1;
        state_next   = flags.cnt_one ? S_FINISH : S_DN_RD;
      end
      S_DN_RD: begin
        cmd.rsel   = RS_CHILD;
        state_next = S_DN_EV;
      end
      S_DN_EV: begin
        cmd.wr_en = 1'b1;
        if (flags.dn_stop) begin
          cmd.wsel   = WS_MOVING;
          state_next = S_FINISH;
        end else begin
          cmd.wsel   = WS_CHILD;
          state_next = S_DN_RD;
        end
      end
      S_UP_RD: begin
        if (flags.pos_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wsel   = WS_MOVING;
          state_next = S_FINISH;
        end else begin
          cmd.rsel   = RS_PARENT;
          state_next = S_UP_EV;
        end
      end
      S_UP_EV: begin
        cmd.wr_en = 1'b1;
        if (flags.up_stop) begin
          cmd.wsel   = WS_MOVING;
          state_next = S_FINISH;
        end else begin
          cmd.wsel   = WS_PARENT;
          state_next = S_UP_RD;
        end
      end
      S_SEARCH: begin
        cmd.rsel = RS_SCAN;
        if (flags.found) begin
          cmd.srch_hit    = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_OK;
          state_next      = S_UP_RD;
        end else if (flags.scan_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/min_heap_priority_queue_unit.sv
// channel | handshake            | payload
// in      | in_valid / in_ready  | operation, zone_id, key_distance, prev_zone
// out     | out_valid / out_ready| status, out_zone, out_distance, out_prev, fill_count
//
// Push sifts the new entry up from the tail until its parent holds a smaller key or it
// reaches the root; pop moves the tail entry to the root and sifts it down (not for the
// last entry). Dropped push, empty pop and unused code go straight to the result.
// Decrease-key scans one entry a cycle: a hit leads to a push-like sift-up, a miss
// answers missing. One item in flight; in_ready is high only when idle. A held result
// stalls the next item in its finish state; rst clears count, state and out_valid.
module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [ZONE_W-1:0]   zone_id,
  input  logic [KEY_W-1:0]    key_distance,
  input  logic [ZONE_W-1:0]   prev_zone,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [ZONE_W-1:0]   out_zone,
  output logic [KEY_W-1:0]    out_distance,
  output logic [ZONE_W-1:0]   out_prev,
  output logic [FILL_W-1:0]   fill_count
);

  cmd_t   cmd;
  flags_t flags;

  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  mhpq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .flags        (flags),
    .zone_id      (zone_id),
    .key_distance (key_distance),
    .prev_zone    (prev_zone),
    .status       (status),
    .out_zone     (out_zone),
    .out_distance (out_distance),
    .out_prev     (out_prev),
    .fill_count   (fill_count)
  );

endmodule

### rtl/core/min_heap_priority_queue_unit_checker.sv
`include "min_heap_priority_queue_unit_macros.svh"

module min_heap_priority_queue_unit_checker
  import mhpq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [ZONE_W-1:0]   out_zone,
  input logic [KEY_W-1:0]    out_distance,
  input logic [ZONE_W-1:0]   out_prev,
  input logic [FILL_W-1:0]   fill_count
);

  logic                                      out_wait;
  logic [2*ZONE_W+KEY_W-1:0]                 pop_fields;
  logic [STATUS_W+2*ZONE_W+KEY_W+FILL_W-1:0] out_word;

  assign out_wait   = out_valid && !out_ready;
  assign pop_fields = {out_zone, out_distance, out_prev};
  assign out_word   = {status, pop_fields, fill_count};

  `MHPQ_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_word))
  `MHPQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `MHPQ_ASSERT_NOW(a_full_count, out_valid && status == ST_FULL, fill_count == FILL_W'(DEPTH))
  `MHPQ_ASSERT_NOW(a_empty_count, out_valid && status == ST_EMPTY, fill_count == '0)
  `MHPQ_ASSERT_NOW(a_error_zero, out_valid && status != ST_OK, pop_fields == '0)

endmodule

bind min_heap_priority_queue_unit min_heap_priority_queue_unit_checker #(
  .DEPTH (DEPTH)
) u_checker (.*);
